@@ design/tst_pkg.sv @@
// Package for the two-slot transposition table: types, codes, constants.
// No dependencies; every other file but tst_checker uses it.
`timescale 1ns / 1ps
`default_nettype none

package tst_pkg;

    localparam int INDEX_BITS = 12;
    localparam int NBUCKETS   = 1 << INDEX_BITS;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    typedef logic [INDEX_BITS-1:0] bucket_idx_t;

    // input kind codes
    localparam logic [1:0] KIND_FIND   = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // bound codes
    localparam logic [1:0] BOUND_LOWER = 2'd1;
    localparam logic [1:0] BOUND_UPPER = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_AGE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATE_BOUND  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MATE_CAP    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_MOVE   = 8'd3;

    localparam logic [7:0]  AGE_RST        = 8'd1;
    localparam logic [14:0] MATE_BOUND_RST = 15'd30000;
    localparam logic [14:0] MATE_CAP_RST   = 15'd30000;
    localparam logic [15:0] MISS_MOVE_RST  = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_FIND,
        OP_INSERT,
        OP_CLEAR
    } op_t;

    typedef enum logic [1:0] {
        ST_WIPE,
        ST_IDLE,
        ST_EXEC
    } back_state_t;

    typedef struct packed {
        logic [7:0]  current_age;
        logic [14:0] mate_bound;
        logic [14:0] mate_cap;
        logic [15:0] miss_move;
    } cfg_t;

    typedef struct packed {
        logic init_busy;
    } back_status_t;

    // classified command handed from front to back
    typedef struct packed {
        op_t                op;
        logic [63:0]        key;
        logic [7:0]         depth;
        logic [1:0]         bound;
        logic [15:0]        move;
        logic signed [15:0] score;
        logic [7:0]         flags;
        logic signed [15:0] beta;
        logic               force_s0;
    } cmd_t;

    typedef struct packed {
        logic [63:0]        key;
        logic [7:0]         age;
        logic [1:0]         bound;
        logic [7:0]         flags;
        logic signed [15:0] score;
        logic [15:0]        move;
        logic [7:0]         depth;
    } slot_t;

    typedef struct packed {
        slot_t s1;
        slot_t s0;
    } bucket_t;

    function automatic slot_t cleared_slot(input logic [15:0] mv);
        slot_t s;
        s       = '0;
        s.move  = mv;
        return s;
    endfunction

endpackage

`default_nettype wire

@@ design/tst_if.sv @@
// Channel interfaces: request, response and configuration write.
// Depends on tst_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

interface tst_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [63:0]        key;
    logic [7:0]         depth;
    logic [1:0]         bound_type;
    logic [15:0]        move_code;
    logic signed [15:0] score;
    logic [7:0]         flags_in;
    logic signed [15:0] beta;

    modport source (output valid, kind, key, depth, bound_type, move_code, score,
                    flags_in, beta, input ready);
    modport sink   (input valid, kind, key, depth, bound_type, move_code, score,
                    flags_in, beta, output ready);
endinterface

interface tst_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         result_bound;
    logic signed [15:0] found_score;
    logic [15:0]        found_move;
    logic               key_hit;
    logic               avoid_null;

    modport source (output valid, result_bound, found_score, found_move, key_hit,
                    avoid_null, input ready);
    modport sink   (input valid, result_bound, found_score, found_move, key_hit,
                    avoid_null, output ready);
endinterface

interface tst_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [tst_pkg::CFG_IDX_W-1:0] index;
    logic [tst_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/tst_front.sv @@
// Front end: accepts request items, drops no-op kinds, treats mate scores.
// Depends on tst_pkg and tst_req_if; feeds tst_queue.
`timescale 1ns / 1ps
`default_nettype none

module tst_front (
    tst_req_if.sink                req,
    input  tst_pkg::cfg_t          cfg,
    input  tst_pkg::back_status_t  status,
    input  logic                   push_ready,
    output logic                   push_valid,
    output tst_pkg::cmd_t          push_cmd
);
    import tst_pkg::*;

    logic [16:0]        score_ext;
    logic [16:0]        mag;
    logic               is_mate;
    logic               pos;
    logic               neg;
    logic               drop;
    logic [1:0]         bt;
    logic signed [15:0] val;
    logic               take;

    assign req.ready = push_ready && !status.init_busy;

    always_comb
    begin
        score_ext = {req.score[15], req.score};
        mag       = req.score[15] ? (17'd0 - score_ext) : score_ext;
        is_mate   = mag >= {2'b00, cfg.mate_bound};
        pos       = !req.score[15] && (req.score != 16'sd0);
        neg       = req.score[15];
        drop      = 1'b0;
        bt        = req.bound_type;
        val       = req.score;
        if (is_mate)
        begin
            if (pos && req.bound_type != BOUND_UPPER)
            begin
                bt  = BOUND_LOWER;
                val = {1'b0, cfg.mate_cap};
            end
            else if (neg && req.bound_type != BOUND_LOWER)
            begin
                bt  = BOUND_UPPER;
                val = 16'd0 - {1'b0, cfg.mate_cap};
            end
            else
            begin
                drop = 1'b1;
            end
        end

        push_cmd          = '0;
        push_cmd.key      = req.key;
        push_cmd.depth    = req.depth;
        push_cmd.bound    = bt;
        push_cmd.move     = req.move_code;
        push_cmd.score    = val;
        push_cmd.flags    = req.flags_in;
        push_cmd.beta     = req.beta;
        // clamped score is still a mate only when the cap reaches the bound
        push_cmd.force_s0 = is_mate && (cfg.mate_cap >= cfg.mate_bound);

        take = 1'b0;
        case (req.kind)
            KIND_FIND:
            begin
                push_cmd.op = OP_FIND;
                take        = 1'b1;
            end
            KIND_INSERT:
            begin
                push_cmd.op = OP_INSERT;
                take        = !drop;
            end
            KIND_CLEAR:
            begin
                push_cmd.op = OP_CLEAR;
                take        = 1'b1;
            end
            default:
            begin
                push_cmd.op = OP_FIND;
                take        = 1'b0;
            end
        endcase
        push_valid = req.valid && req.ready && take;
    end

endmodule

`default_nettype wire

@@ design/tst_queue.sv @@
// Short command queue between the front and back ends.
// Depends on tst_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none

module tst_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  tst_pkg::cmd_t  push_cmd,
    output logic           pop_valid,
    input  logic           pop,
    output tst_pkg::cmd_t  pop_cmd
);
    import tst_pkg::*;

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != QCNT_W'(QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ design/tst_back.sv @@
// Back end: bucket memory, read-modify-write sequencer, wipe sweep, result register.
// Depends on tst_pkg and tst_rsp_if; fed by tst_queue.
`timescale 1ns / 1ps
`default_nettype none

module tst_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tst_pkg::cfg_t          cfg,
    input  logic                   q_valid,
    input  tst_pkg::cmd_t          q_cmd,
    output logic                   q_pop,
    output tst_pkg::back_status_t  status,
    tst_rsp_if.source              rsp
);
    import tst_pkg::*;

    bucket_t            mem [NBUCKETS];
    bucket_t            rdata_reg;
    back_state_t        state_reg;
    back_state_t        state_next;
    cmd_t               cmd_reg;
    bucket_idx_t        wipe_cnt_reg;
    bucket_idx_t        wipe_cnt_next;
    logic [15:0]        wipe_move_reg;
    logic [15:0]        wipe_move_next;
    logic               init_reg;
    logic               init_next;

    logic               mem_re;
    logic               mem_we;
    bucket_idx_t        mem_raddr;
    bucket_idx_t        mem_waddr;
    bucket_t            mem_wdata;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               load_out;
    logic [1:0]         out_bound_reg;
    logic signed [15:0] out_score_reg;
    logic [15:0]        out_move_reg;
    logic               out_hit_reg;
    logic               out_avoid_reg;

    // find
    logic               hit0;
    logic               hit1;
    slot_t              hit_slot;
    logic [1:0]         f_bound;
    logic signed [15:0] f_score;
    logic [15:0]        f_move;
    logic               f_hit;
    logic               f_avoid;

    // insert
    logic               same;
    logic               repl;
    slot_t              new_slot;
    bucket_t            ins_bucket;
    logic               ins_write;

    assign status.init_busy = init_reg;
    assign rsp.valid        = out_valid_reg;
    assign rsp.result_bound = out_bound_reg;
    assign rsp.found_score  = out_score_reg;
    assign rsp.found_move   = out_move_reg;
    assign rsp.key_hit      = out_hit_reg;
    assign rsp.avoid_null   = out_avoid_reg;

    always_comb
    begin
        hit0     = rdata_reg.s0.key == cmd_reg.key;
        hit1     = rdata_reg.s1.key == cmd_reg.key;
        hit_slot = hit0 ? rdata_reg.s0 : rdata_reg.s1;
        f_hit    = hit0 || hit1;
        if (f_hit)
        begin
            f_bound = (hit_slot.depth < cmd_reg.depth) ? 2'd0 : hit_slot.bound;
            f_score = hit_slot.score;
            f_move  = hit_slot.move;
            f_avoid = (hit_slot.bound != BOUND_LOWER)
                      && ($signed(hit_slot.score) < $signed(cmd_reg.beta));
        end
        else
        begin
            f_bound = 2'd0;
            f_score = 16'sd0;
            f_move  = cfg.miss_move;
            f_avoid = 1'b0;
        end
    end

    always_comb
    begin
        same           = hit0;
        repl           = (rdata_reg.s0.depth <= cmd_reg.depth)
                         || (rdata_reg.s0.age != cfg.current_age)
                         || cmd_reg.force_s0;
        new_slot.key   = cmd_reg.key;
        new_slot.age   = cfg.current_age;
        new_slot.bound = cmd_reg.bound;
        new_slot.flags = cmd_reg.flags;
        new_slot.score = cmd_reg.score;
        new_slot.move  = cmd_reg.move;
        new_slot.depth = cmd_reg.depth;
        ins_bucket     = rdata_reg;
        ins_write      = 1'b1;
        if (repl)
        begin
            // same key keeps its old move when the new item carries none
            if (same && cmd_reg.move == 16'd0)
            begin
                new_slot.move = rdata_reg.s0.move;
            end
            ins_bucket.s0 = new_slot;
            ins_bucket.s1 = same ? rdata_reg.s1 : rdata_reg.s0;
        end
        else if (!same)
        begin
            ins_bucket.s1 = new_slot;
        end
        else
        begin
            ins_write = 1'b0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        wipe_cnt_next  = wipe_cnt_reg;
        wipe_move_next = wipe_move_reg;
        init_next      = init_reg;
        q_pop          = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = q_cmd.key[INDEX_BITS-1:0];
        mem_we         = 1'b0;
        mem_waddr      = cmd_reg.key[INDEX_BITS-1:0];
        mem_wdata      = ins_bucket;
        load_out       = 1'b0;
        case (state_reg)
            ST_WIPE:
            begin
                mem_we        = 1'b1;
                mem_waddr     = wipe_cnt_reg;
                mem_wdata.s0  = cleared_slot(wipe_move_reg);
                mem_wdata.s1  = cleared_slot(wipe_move_reg);
                wipe_cnt_next = wipe_cnt_reg + 1'b1;
                if (wipe_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                    init_next  = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop  = 1'b1;
                    mem_re = 1'b1;
                    if (q_cmd.op == OP_CLEAR)
                    begin
                        state_next     = ST_WIPE;
                        wipe_cnt_next  = '0;
                        wipe_move_next = cfg.miss_move;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                if (cmd_reg.op == OP_FIND)
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    mem_we     = ins_write;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WIPE;
            wipe_cnt_reg  <= '0;
            wipe_move_reg <= MISS_MOVE_RST;
            init_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wipe_cnt_reg  <= wipe_cnt_next;
            wipe_move_reg <= wipe_move_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
        end
        if (load_out)
        begin
            out_bound_reg <= f_bound;
            out_score_reg <= f_score;
            out_move_reg  <= f_move;
            out_hit_reg   <= f_hit;
            out_avoid_reg <= f_avoid;
        end
    end

    // bucket store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/two_slot_transposition_table_core.sv @@
// Two-slot transposition table, top level. Find and insert run in the back end as a
// bucket read, then a modify/write; a find result passes the queue, read register and
// result register, and waits on a stalled older result. A clear sweeps 2^INDEX_BITS
// buckets, one per cycle. After reset a pass clears all 4096 with req.ready low;
// configuration writes are taken throughout. Registers reset to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module two_slot_transposition_table_core (
    input  logic       clk,
    input  logic       rst_n,
    tst_req_if.sink    req,
    tst_rsp_if.source  rsp,
    tst_cfg_if.sink    cfg
);
    import tst_pkg::*;

    cfg_t          cfg_reg;
    back_status_t  status;
    logic          push_valid;
    logic          push_ready;
    cmd_t          push_cmd;
    logic          q_valid;
    logic          q_pop;
    cmd_t          q_cmd;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.current_age <= AGE_RST;
            cfg_reg.mate_bound  <= MATE_BOUND_RST;
            cfg_reg.mate_cap    <= MATE_CAP_RST;
            cfg_reg.miss_move   <= MISS_MOVE_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_CURRENT_AGE: cfg_reg.current_age <= cfg.data[7:0];
                CFG_MATE_BOUND:  cfg_reg.mate_bound  <= cfg.data[14:0];
                CFG_MATE_CAP:    cfg_reg.mate_cap    <= cfg.data[14:0];
                CFG_MISS_MOVE:   cfg_reg.miss_move   <= cfg.data[15:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    tst_front u_front (
        .req        (req),
        .cfg        (cfg_reg),
        .status     (status),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    tst_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_cmd    (q_cmd)
    );

    tst_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .status  (status),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire

@@ design/tst_checker.sv @@
// Port-level checks for the transposition table core, bound to the top level.
// Depends on the top level's channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module tst_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_ready,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  logic [1:0]  rsp_result_bound,
    input  logic [15:0] rsp_found_score,
    input  logic [15:0] rsp_found_move,
    input  logic        rsp_key_hit,
    input  logic        rsp_avoid_null
);

    // a stalled result stays valid with its move and score held
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found_move)
                                    && $stable(rsp_found_score))
        else $error("stalled result changed");

    // the clearing pass keeps requests out right after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !req_ready)
        else $error("request taken during clearing pass");

    // a miss reports neutral fields
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_key_hit |-> rsp_result_bound == 2'd0
                                      && rsp_found_score == 16'd0 && !rsp_avoid_null)
        else $error("miss with non-neutral fields");

    // a usable bound needs a hit
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_result_bound != 2'd0 |-> rsp_key_hit)
        else $error("bound reported without hit");

endmodule

bind two_slot_transposition_table_core tst_checker u_tst_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_result_bound (rsp.result_bound),
    .rsp_found_score  (rsp.found_score),
    .rsp_found_move   (rsp.found_move),
    .rsp_key_hit      (rsp.key_hit),
    .rsp_avoid_null   (rsp.avoid_null)
);

`default_nettype wire
